// File: rtl/core/dtc_pkg.sv
// Shared types and constants for the domino tiling counter.
// Used by dtc_ctrl, dtc_datapath, domino_tiling_counter and dtc_checker; no dependencies.
package dtc_pkg;

	localparam int SIDE_BITS = 7;   // width of one grid side
	localparam int OUT_BITS  = 64;  // width of the tiling count port

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_INIT,
		ST_CELL,
		ST_DRAIN,
		ST_REPORT
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture sides, clear row/col/index
		logic idx_clr;
		logic idx_inc;
		logic init_wr;    // write seed entry for current index
		logic sweep_rd;   // issue reads for current target profile
		logic next_cell;  // advance column/row, swap banks
	} dtc_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic idx_last;   // index is at the full profile
		logic last_cell;  // current cell is the last of the grid
		logic special;    // too wide or empty grid: no sweep
		logic pipe_busy;  // an accumulate is still in flight
	} dtc_status_t;

endpackage

// File: rtl/core/dtc_ctrl.sv
// Sequencer for the domino tiling counter.
// Depends on dtc_pkg (state enum, command and status structs).
module dtc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output dtc_pkg::dtc_cmd_t     cmd,
	input  dtc_pkg::dtc_status_t  status
);

	dtc_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			dtc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = dtc_pkg::ST_SETUP;
				end
			end
			dtc_pkg::ST_SETUP: begin
				state_d = status.special ? dtc_pkg::ST_REPORT : dtc_pkg::ST_INIT;
			end
			dtc_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (status.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = dtc_pkg::ST_CELL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			dtc_pkg::ST_CELL: begin
				cmd.sweep_rd = 1'b1;
				if (status.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = dtc_pkg::ST_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			dtc_pkg::ST_DRAIN: begin
				// hold until the last accumulate of the cell is written
				if (!status.pipe_busy) begin
					if (status.last_cell) begin
						state_d = dtc_pkg::ST_REPORT;
					end else begin
						cmd.next_cell = 1'b1;
						state_d       = dtc_pkg::ST_CELL;
					end
				end
			end
			dtc_pkg::ST_REPORT: begin
				done    = 1'b1;
				state_d = dtc_pkg::ST_IDLE;
			end
			default: begin
				state_d = dtc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/dtc_datapath.sv
// Profile-count memory, index/cell counters and accumulate pipeline.
// Depends on dtc_pkg (command and status structs, port widths).
module dtc_datapath #(
	parameter int MAX_WIDTH  = 10,
	parameter int COUNT_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dtc_pkg::dtc_cmd_t                 cmd,
	output dtc_pkg::dtc_status_t              status,
	input  logic [dtc_pkg::SIDE_BITS-1:0]     side_a,
	input  logic [dtc_pkg::SIDE_BITS-1:0]     side_b,
	output logic [dtc_pkg::OUT_BITS-1:0]      tiling_count,
	output logic                              too_wide
);

	localparam int PW    = MAX_WIDTH;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int AW    = PW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam int SB    = dtc_pkg::SIDE_BITS;

	logic [SB-1:0]         shorter, longer;
	logic [PW-1:0]         full_d, top_d;

	logic [CW-1:0]         w_q, col_q;
	logic [SB-1:0]         h_q, row_q;
	logic [PW-1:0]         full_q, top_q, idx_q;
	logic                  wide_q, zero_q, bank_q;

	logic [PW:0]           idx_ext;
	logic [PW-1:0]         half, addr0, addr1;
	logic                  first_col, last_col, last_row;

	logic                  v_s1, add_s1;
	logic [PW-1:0]         idx_s1;
	logic [COUNT_BITS-1:0] rd0_s1, rd1_s1;
	logic [COUNT_BITS-1:0] sum, result_q;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	logic [COUNT_BITS-1:0] mem [DEPTH];

	assign shorter = (side_a < side_b) ? side_a : side_b;
	assign longer  = (side_a < side_b) ? side_b : side_a;

	// profile masks for the shorter side
	always_comb begin
		for (int i = 0; i < PW; i++) begin
			full_d[i] = shorter > SB'(i);
			top_d[i]  = shorter == SB'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= shorter[CW-1:0];
			h_q    <= longer;
			full_q <= full_d;
			top_q  <= top_d;
			wide_q <= shorter > SB'(MAX_WIDTH);
			zero_q <= shorter == '0;
		end
	end

	assign first_col = col_q == '0;
	assign last_col  = col_q == (w_q - CW'(1));
	assign last_row  = row_q == (h_q - SB'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			idx_q  <= '0;
			bank_q <= 1'b0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep_rd;
			if (cmd.load) begin
				col_q <= '0;
				row_q <= '0;
				idx_q <= '0;
			end else begin
				if (cmd.idx_clr) begin
					idx_q <= '0;
				end else if (cmd.idx_inc) begin
					idx_q <= idx_q + PW'(1);
				end
				if (cmd.next_cell) begin
					bank_q <= ~bank_q;
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + SB'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
		end
	end

	// Pull form of the cell step: target profile d takes
	//   bit0 clear: old[top | d>>1]
	//   bit0 set:   old[d>>1] plus, past the first column with bit1 set,
	//               old[top | (d>>1 with bit0 cleared)] (horizontal domino)
	assign idx_ext = {1'b0, idx_q};
	assign half    = idx_q >> 1;
	assign addr0   = idx_q[0] ? half : (top_q | half);
	assign addr1   = top_q | (half & ~PW'(1));

	always_ff @(posedge clk) begin
		if (cmd.sweep_rd) begin
			rd0_s1 <= mem[{bank_q, addr0}];
			rd1_s1 <= mem[{bank_q, addr1}];
			idx_s1 <= idx_q;
			add_s1 <= !first_col && idx_q[0] && idx_ext[1];
		end
	end

	assign sum = rd0_s1 + (add_s1 ? rd1_s1 : '0);

	// seed writes go to the source bank, accumulates to the other one
	assign wr_en   = cmd.init_wr | v_s1;
	assign wr_addr = cmd.init_wr ? {bank_q, idx_q} : {~bank_q, idx_s1};
	assign wr_data = cmd.init_wr ? ((idx_q == full_q) ? COUNT_BITS'(1) : '0) : sum;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && idx_s1 == full_q) begin
			result_q <= sum;
		end
	end

	assign status.idx_last  = idx_q == full_q;
	assign status.last_cell = last_col && last_row;
	assign status.special   = wide_q | zero_q;
	assign status.pipe_busy = v_s1;

	assign tiling_count = zero_q ? dtc_pkg::OUT_BITS'(1) :
	                      wide_q ? '0 : dtc_pkg::OUT_BITS'(result_q);
	assign too_wide     = wide_q;

endmodule

// File: rtl/core/domino_tiling_counter.sv
// Top level of the domino tiling counter: controller plus datapath.
// Depends on dtc_pkg, dtc_ctrl and dtc_datapath.
//
// Usage:
//   Raise start with side_a/side_b valid; the word is taken at the clock
//   edge where start is high and busy is low. busy stays high until the
//   result has been shown. The result word (tiling_count, too_wide) is on
//   its ports for exactly one cycle, marked by done; the receiver has no
//   way to stall it and must take it in that cycle.
// Sequence (w = shorter side, h = longer side, both 1..MAX_WIDTH / 1..127):
//   after the accepting edge the block sweeps all 2^w profiles through the
//   single write port of the profile memory, once to seed a bank and once
//   per cell of the w*h grid; after each cell sweep the read-then-accumulate
//   pipeline drains before the banks swap or the result is reported.
//   A grid wider than MAX_WIDTH, or with an empty side, skips the sweeps
//   and reports directly.
// One job at a time; the next start is taken the cycle after done.
// Reset: arst_n clears the controller and counters asynchronously. The
//   profile memory needs no clearing: each job seeds every entry it reads.
module domino_tiling_counter #(
	parameter int MAX_WIDTH  = 10,
	parameter int COUNT_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [dtc_pkg::SIDE_BITS-1:0]  side_a,
	input  logic [dtc_pkg::SIDE_BITS-1:0]  side_b,
	output logic                           done,
	output logic [dtc_pkg::OUT_BITS-1:0]   tiling_count,
	output logic                           too_wide
);

	dtc_pkg::dtc_cmd_t    cmd;
	dtc_pkg::dtc_status_t status;

	// sequencing: seed, per-cell sweeps, drain, report
	dtc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// two banks of profile counts and the accumulate pipeline
	dtc_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.side_a       (side_a),
		.side_b       (side_b),
		.tiling_count (tiling_count),
		.too_wide     (too_wide)
	);

endmodule

// File: rtl/core/dtc_checker.sv
// Port-level checks for domino_tiling_counter, attached by bind.
// Depends on dtc_pkg for port widths.
module dtc_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [dtc_pkg::SIDE_BITS-1:0]  side_a,
	input logic [dtc_pkg::SIDE_BITS-1:0]  side_b,
	input logic                           done,
	input logic [dtc_pkg::OUT_BITS-1:0]   tiling_count,
	input logic                           too_wide
);

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result only appears while a job is open
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a job");

	// one result per job, then back to idle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe repeated or block stayed busy");

	// a too-wide grid reports a zero count
	a_wide_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && too_wide |-> tiling_count == '0)
		else $error("too-wide result with nonzero count");

endmodule

bind domino_tiling_counter dtc_props u_dtc_props (.*);

// File: dv/dtc_checker.sv
`timescale 1ns / 100ps
// Checker for the domino tiling counter: watches the job and result words, predicts each count.
// Depends on dtc_pkg; instantiated beside the block by tb_domino_tiling_counter.
module dtc_checker #(
	parameter int MAX_WIDTH  = 10,
	parameter int COUNT_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [dtc_pkg::SIDE_BITS-1:0] side_a,
	input  logic [dtc_pkg::SIDE_BITS-1:0] side_b,
	input  logic                          done,
	input  logic [dtc_pkg::OUT_BITS-1:0]  tiling_count,
	input  logic                          too_wide,
	output int                            fail_count,
	output int                            pending_jobs
);

	localparam int BANK_SIZE = 1 << MAX_WIDTH;
	localparam logic [63:0] COUNT_MASK = (COUNT_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << COUNT_BITS) - 64'd1);

	typedef struct {
		logic [dtc_pkg::OUT_BITS-1:0] count;
		logic                         wide;
	} tiling_result_t;

	tiling_result_t expected_tilings[$];
	logic [63:0]    profile_counts [2][BANK_SIZE];
	bit             active_bank;
	int             errors;

	assign fail_count   = errors;
	assign pending_jobs = expected_tilings.size();

	function automatic void add_profile(input int bank, input int prof, input logic [63:0] c);
		profile_counts[bank][prof] = (profile_counts[bank][prof] + c) & COUNT_MASK;
	endfunction

	// Broken-profile sweep over the shorter side, one cell at a time.
	function automatic tiling_result_t count_tilings(input logic [dtc_pkg::SIDE_BITS-1:0] a,
			input logic [dtc_pkg::SIDE_BITS-1:0] b);
		tiling_result_t res;
		int w, h, full, top, row, col, prof, src, dst, shifted;
		logic [63:0] c;
		w = (a < b) ? int'(a) : int'(b);
		h = (a < b) ? int'(b) : int'(a);
		res.wide = 1'b0;
		if (w > MAX_WIDTH) begin
			res.count = '0;
			res.wide  = 1'b1;
		end else if (w == 0) begin
			res.count = dtc_pkg::OUT_BITS'(1);
		end else begin
			full = (1 << w) - 1;
			top  = 1 << (w - 1);
			src  = active_bank;
			for (prof = 0; prof < BANK_SIZE; prof++)
				profile_counts[src][prof] = '0;
			profile_counts[src][full] = 64'd1;
			for (row = 0; row < h; row++) begin
				for (col = 0; col < w; col++) begin
					src = active_bank;
					dst = src ^ 1;
					for (prof = 0; prof < BANK_SIZE; prof++)
						profile_counts[dst][prof] = '0;
					for (prof = 0; prof <= full; prof++) begin
						c = profile_counts[src][prof];
						if (c != 0) begin
							if (prof & top) begin
								shifted = ((prof ^ top) << 1) & full;
								add_profile(dst, shifted, c);
								// horizontal domino needs an open left neighbor
								if (col != 0 && (prof & 1) == 0)
									add_profile(dst, (shifted | 3) & full, c);
							end else begin
								add_profile(dst, ((prof << 1) | 1) & full, c);
							end
						end
					end
					active_bank = dst[0];
				end
			end
			res.count = profile_counts[active_bank][full] & COUNT_MASK;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tiling_result_t exp_res;
		if (!arst_n) begin
			active_bank = 1'b0;
			for (int i = 0; i < BANK_SIZE; i++) begin
				profile_counts[0][i] = '0;
				profile_counts[1][i] = '0;
			end
		end else begin
			if (done) begin
				if (expected_tilings.size() == 0) begin
					$error("result word with no job outstanding: tiling_count %0d too_wide %0b",
						tiling_count, too_wide);
					errors++;
				end else begin
					exp_res = expected_tilings.pop_front();
					if (tiling_count !== exp_res.count) begin
						$error("tiling_count mismatch: expected %0d, actual %0d",
							exp_res.count, tiling_count);
						errors++;
					end
					if (too_wide !== exp_res.wide) begin
						$error("too_wide mismatch: expected %0b, actual %0b",
							exp_res.wide, too_wide);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_tilings.push_back(count_tilings(side_a, side_b));
		end
	end

endmodule

// File: dv/tb_domino_tiling_counter.sv
`timescale 1ns / 100ps
// Testbench top for the domino tiling counter: clock, reset, job stimulus and verdict.
// Depends on dtc_pkg, domino_tiling_counter and dtc_checker.
module tb_domino_tiling_counter;

	// Worst correct wait is the 10x10 job; allow several times that.
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int RANDOM_JOBS    = 76;
	localparam int END_CYCLES     = 20;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [dtc_pkg::SIDE_BITS-1:0] side_a;
	logic [dtc_pkg::SIDE_BITS-1:0] side_b;
	logic                          done;
	logic [dtc_pkg::OUT_BITS-1:0]  tiling_count;
	logic                          too_wide;
	int                            fail_count;
	int                            pending_jobs;
	int                            quiet_cycles;

	domino_tiling_counter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.side_a       (side_a),
		.side_b       (side_b),
		.done         (done),
		.tiling_count (tiling_count),
		.too_wide     (too_wide)
	);

	dtc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.side_a       (side_a),
		.side_b       (side_b),
		.done         (done),
		.tiling_count (tiling_count),
		.too_wide     (too_wide),
		.fail_count   (fail_count),
		.pending_jobs (pending_jobs)
	);

	// 12 ns period, low phase first
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: count cycles in which neither a job nor a result word moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[domino_tiling_counter] ERROR");
				$finish;
			end
		end
	end

	// Present one job word at the falling edge and hold it until the block takes it.
	// Return at the next falling edge with start still high, so a back-to-back
	// job simply overwrites the sides.
	task automatic send_job(input logic [dtc_pkg::SIDE_BITS-1:0] a,
			input logic [dtc_pkg::SIDE_BITS-1:0] b);
		logic taken;
		start  <= 1'b1;
		side_a <= a;
		side_b <= b;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		@(negedge clk);
	endtask

	// Drop start for a number of cycles and wiggle the sides as noise.
	task automatic hold_off(input int cycles);
		start  <= 1'b0;
		side_a <= dtc_pkg::SIDE_BITS'($urandom);
		side_b <= dtc_pkg::SIDE_BITS'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	// Drop start and wait until every outstanding job has reported.
	task automatic drain_jobs();
		start <= 1'b0;
		@(negedge clk);
		while (pending_jobs != 0)
			@(negedge clk);
	endtask

	// Pick one random job. Most are narrow grids so the sweep stays short;
	// a few reach the full profile width with few rows.
	task automatic pick_job(output logic [dtc_pkg::SIDE_BITS-1:0] a,
			output logic [dtc_pkg::SIDE_BITS-1:0] b);
		int kind, w, h;
		logic [dtc_pkg::SIDE_BITS-1:0] t;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			// too wide: both sides past the profile width
			w = $urandom_range(11, 127);
			h = $urandom_range(11, 127);
		end else if (kind < 22) begin
			// empty grid
			w = 0;
			h = $urandom_range(0, 127);
		end else if (kind < 62) begin
			w = $urandom_range(1, 3);
			h = $urandom_range(1, 127);
		end else if (kind < 92) begin
			w = $urandom_range(4, 6);
			h = $urandom_range(1, 14);
		end else begin
			w = $urandom_range(7, 10);
			h = $urandom_range(1, 3);
		end
		a = dtc_pkg::SIDE_BITS'(w);
		b = dtc_pkg::SIDE_BITS'(h);
		if ($urandom_range(0, 1)) begin
			t = a;
			a = b;
			b = t;
		end
	endtask

	initial begin
		logic [dtc_pkg::SIDE_BITS-1:0] ra, rb;
		int jobs_sent, burst;
		arst_n = 1'b0;
		start  = 1'b0;
		side_a = '0;
		side_b = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty grids, too-wide grids, odd cell counts, field extremes.
		send_job(7'd0, 7'd5);
		send_job(7'd5, 7'd0);
		send_job(7'd0, 7'd0);
		send_job(7'd0, 7'd127);
		send_job(7'd127, 7'd127);
		send_job(7'd11, 7'd11);
		send_job(7'd11, 7'd127);
		send_job(7'd127, 7'd11);
		hold_off(3);
		send_job(7'd1, 7'd1);
		send_job(7'd1, 7'd2);
		send_job(7'd2, 7'd1);
		send_job(7'd1, 7'd127);
		send_job(7'd127, 7'd2);
		send_job(7'd2, 7'd2);
		send_job(7'd3, 7'd3);
		send_job(7'd2, 7'd3);
		send_job(7'd4, 7'd4);
		send_job(7'd3, 7'd127);
		send_job(7'd127, 7'd4);
		send_job(7'd6, 7'd7);
		send_job(7'd8, 7'd8);
		send_job(7'd10, 7'd1);
		send_job(7'd10, 7'd10);
		drain_jobs();

		// Random part: bursts of jobs separated by random gaps, some bursts back to back.
		jobs_sent = 0;
		while (jobs_sent < RANDOM_JOBS) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && jobs_sent < RANDOM_JOBS) begin
				pick_job(ra, rb);
				send_job(ra, rb);
				jobs_sent++;
				burst--;
				if (jobs_sent == RANDOM_JOBS / 2)
					drain_jobs();
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 15));
		end

		// Flush: wait out the last job, then a short tail for stray result words.
		drain_jobs();
		repeat (END_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_jobs == 0) begin
			$display("[domino_tiling_counter] OK");
		end else begin
			$display("[domino_tiling_counter] ERROR");
		end
		$finish;
	end

endmodule
